>>> rtl/core/psw_pkg.sv
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants of the priority scheduler.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int ID_W    = 5;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 20;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ROW,
        ST_CUR,
        ST_CMP,
        ST_WBI,
        ST_ERD,
        ST_EDAT,
        ST_DW0,
        ST_DW1,
        ST_DT0,
        ST_DT1,
        ST_LAST
    } t_state;

    // clamp a time value to the 20-bit output range
    function automatic logic [TIME_W-1:0] sat_time(input logic [63:0] v);
        logic [TIME_W-1:0] res;
        if (v > 64'(TIME_MAX)) begin
            res = TIME_MAX;
        end else begin
            res = v[TIME_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/psw_store.sv
// ----------------------------------------------------------------------------
// psw_store
// Job memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psw_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  psw_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output psw_pkg::t_entry o_rdata
);

    psw_pkg::t_entry r_mem [DEPTH];
    psw_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/psw_div.sv
// ----------------------------------------------------------------------------
// psw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psw_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int LW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [LW-1:0]    r_left;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_dvd;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= LW'(DVD_W);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == LW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

>>> rtl/core/priority_schedule_wait_times.sv
// ----------------------------------------------------------------------------
// priority_schedule_wait_times
// Non-preemptive priority scheduler: stores a set of jobs, orders them by
// priority and reports wait and turnaround times in run order.
//
// Input channel (i_in_valid / o_in_ready): one job per item, burst time,
// priority and a last-job mark. Jobs are taken one per cycle while loading;
// the item with the last mark starts scheduling. Jobs beyond MAX_JOBS are
// dropped and reported through o_overflowed on the final result.
// Output channel (o_out_valid / i_out_ready): one result per stored job, in
// run order; the final one carries the truncated averages.
// After the last job, for n stored jobs, the exchange sort makes n*(n-1)/2
// compares over one memory read port and one priority comparator. Each
// result then goes through a memory read and then the output register;
// before the final result the shared divider runs twice, once per average.
// The input is not ready from the last job until the final result sits in
// the output register. A stalled receiver holds the output register and
// stops the sequencer. Reset empties the job set and the output register.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times #(
    parameter int MAX_JOBS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_burst_time,
    input  logic [7:0]  i_job_priority,
    input  logic        i_last_job,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_job_id,
    output logic [15:0] o_job_burst,
    output logic [19:0] o_wait_time,
    output logic [19:0] o_turnaround,
    output logic [19:0] o_avg_wait,
    output logic [19:0] o_avg_turnaround,
    output logic        o_overflowed,
    output logic        o_final_result
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int WAIT_W = psw_pkg::BURST_W + CNT_W;
    localparam int SUM_W  = WAIT_W + CNT_W;
    localparam int TW     = psw_pkg::TIME_W;

    psw_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    psw_pkg::t_entry  r_cur, n_cur;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [SUM_W-1:0]  r_sum_w, n_sum_w;
    logic [SUM_W-1:0]  r_sum_t, n_sum_t;
    logic [TW-1:0]     r_avg_w, n_avg_w;
    logic [TW-1:0]     r_avg_t, n_avg_t;

    logic                       r_ov, n_ov;
    logic [psw_pkg::ID_W-1:0]   r_o_id, n_o_id;
    logic [psw_pkg::BURST_W-1:0] r_o_burst, n_o_burst;
    logic [TW-1:0]              r_o_wait, n_o_wait;
    logic [TW-1:0]              r_o_turn, n_o_turn;
    logic [TW-1:0]              r_o_avg_w, n_o_avg_w;
    logic [TW-1:0]              r_o_avg_t, n_o_avg_t;
    logic                       r_o_ovf, n_o_ovf;
    logic                       r_o_fin, n_o_fin;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    psw_pkg::t_entry  mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    psw_pkg::t_entry  mem_rdata;

    logic             div_start;
    logic [SUM_W-1:0] div_dvd;
    logic             div_done;
    logic [SUM_W-1:0] div_quo;

    logic                        accept;
    logic                        slot_free;
    logic [CNT_W+psw_pkg::ID_W-1:0] id_ext;
    logic [WAIT_W-1:0]           turn;
    logic                        i_next_ok;
    logic                        j_next_ok;
    logic                        k_is_last;

    psw_store #(
        .DEPTH (MAX_JOBS),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    psw_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_cur     = r_cur;
        n_wait    = r_wait;
        n_sum_w   = r_sum_w;
        n_sum_t   = r_sum_t;
        n_avg_w   = r_avg_w;
        n_avg_t   = r_avg_t;
        n_o_id    = r_o_id;
        n_o_burst = r_o_burst;
        n_o_wait  = r_o_wait;
        n_o_turn  = r_o_turn;
        n_o_avg_w = r_o_avg_w;
        n_o_avg_t = r_o_avg_t;
        n_o_ovf   = r_o_ovf;
        n_o_fin   = r_o_fin;

        o_in_ready = (r_state == psw_pkg::ST_LOAD);
        accept     = i_in_valid && o_in_ready;
        slot_free  = !r_ov || i_out_ready;
        n_ov       = r_ov && !i_out_ready;

        mem_we    = 1'b0;
        mem_waddr = r_cnt[IDX_W-1:0];
        mem_wdata = r_cur;
        mem_re    = 1'b0;
        mem_raddr = r_i[IDX_W-1:0];
        div_start = 1'b0;
        div_dvd   = (r_state == psw_pkg::ST_DT0) ? r_sum_t : r_sum_w;

        id_ext    = (CNT_W + psw_pkg::ID_W)'(r_cnt) + 1'b1;
        turn      = r_wait + WAIT_W'(mem_rdata.burst);
        i_next_ok = (({1'b0, r_i} + 1'b1) < {1'b0, r_cnt});
        j_next_ok = (({1'b0, r_j} + 1'b1) < {1'b0, r_cnt});
        k_is_last = (({1'b0, r_k} + 1'b1) == {1'b0, r_cnt});

        case (r_state)
            psw_pkg::ST_LOAD: begin
                if (accept) begin
                    if (r_cnt != CNT_W'(MAX_JOBS)) begin
                        mem_we          = 1'b1;
                        mem_wdata.id    = id_ext[psw_pkg::ID_W-1:0];
                        mem_wdata.burst = i_burst_time;
                        mem_wdata.prio  = i_job_priority;
                        n_cnt           = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_job) begin
                        n_i     = '0;
                        n_state = psw_pkg::ST_ROW;
                    end
                end
            end
            psw_pkg::ST_ROW: begin
                if (r_cnt == '0) begin
                    n_drop  = 1'b0;
                    n_state = psw_pkg::ST_LOAD;
                end else if (i_next_ok) begin
                    mem_re  = 1'b1;
                    n_state = psw_pkg::ST_CUR;
                end else begin
                    n_k     = '0;
                    n_wait  = '0;
                    n_sum_w = '0;
                    n_sum_t = '0;
                    n_state = psw_pkg::ST_ERD;
                end
            end
            psw_pkg::ST_CUR: begin
                // entry i becomes the running candidate of this row
                n_cur     = mem_rdata;
                n_j       = r_i + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = n_j[IDX_W-1:0];
                n_state   = psw_pkg::ST_CMP;
            end
            psw_pkg::ST_CMP: begin
                if (r_cur.prio > mem_rdata.prio) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j[IDX_W-1:0];
                    mem_wdata = r_cur;
                    n_cur     = mem_rdata;
                end
                if (j_next_ok) begin
                    n_j       = r_j + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = n_j[IDX_W-1:0];
                end else begin
                    n_state = psw_pkg::ST_WBI;
                end
            end
            psw_pkg::ST_WBI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[IDX_W-1:0];
                mem_wdata = r_cur;
                n_i       = r_i + 1'b1;
                n_state   = psw_pkg::ST_ROW;
            end
            psw_pkg::ST_ERD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k[IDX_W-1:0];
                n_state   = psw_pkg::ST_EDAT;
            end
            psw_pkg::ST_EDAT: begin
                if (k_is_last) begin
                    // last job waits for the averages
                    n_sum_w = r_sum_w + SUM_W'(r_wait);
                    n_sum_t = r_sum_t + SUM_W'(turn);
                    n_state = psw_pkg::ST_DW0;
                end else if (slot_free) begin
                    n_ov      = 1'b1;
                    n_o_id    = mem_rdata.id;
                    n_o_burst = mem_rdata.burst;
                    n_o_wait  = psw_pkg::sat_time(64'(r_wait));
                    n_o_turn  = psw_pkg::sat_time(64'(turn));
                    n_o_avg_w = '0;
                    n_o_avg_t = '0;
                    n_o_ovf   = 1'b0;
                    n_o_fin   = 1'b0;
                    n_sum_w   = r_sum_w + SUM_W'(r_wait);
                    n_sum_t   = r_sum_t + SUM_W'(turn);
                    n_wait    = turn;
                    n_k       = r_k + 1'b1;
                    n_state   = psw_pkg::ST_ERD;
                end
            end
            psw_pkg::ST_DW0: begin
                div_start = 1'b1;
                n_state   = psw_pkg::ST_DW1;
            end
            psw_pkg::ST_DW1: begin
                if (div_done) begin
                    n_avg_w = psw_pkg::sat_time(64'(div_quo));
                    n_state = psw_pkg::ST_DT0;
                end
            end
            psw_pkg::ST_DT0: begin
                div_start = 1'b1;
                n_state   = psw_pkg::ST_DT1;
            end
            psw_pkg::ST_DT1: begin
                if (div_done) begin
                    n_avg_t = psw_pkg::sat_time(64'(div_quo));
                    n_state = psw_pkg::ST_LAST;
                end
            end
            psw_pkg::ST_LAST: begin
                if (slot_free) begin
                    n_ov      = 1'b1;
                    n_o_id    = mem_rdata.id;
                    n_o_burst = mem_rdata.burst;
                    n_o_wait  = psw_pkg::sat_time(64'(r_wait));
                    n_o_turn  = psw_pkg::sat_time(64'(turn));
                    n_o_avg_w = r_avg_w;
                    n_o_avg_t = r_avg_t;
                    n_o_ovf   = r_drop;
                    n_o_fin   = 1'b1;
                    n_cnt     = '0;
                    n_drop    = 1'b0;
                    n_state   = psw_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = psw_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psw_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_wait    <= n_wait;
        r_sum_w   <= n_sum_w;
        r_sum_t   <= n_sum_t;
        r_avg_w   <= n_avg_w;
        r_avg_t   <= n_avg_t;
        r_o_id    <= n_o_id;
        r_o_burst <= n_o_burst;
        r_o_wait  <= n_o_wait;
        r_o_turn  <= n_o_turn;
        r_o_avg_w <= n_o_avg_w;
        r_o_avg_t <= n_o_avg_t;
        r_o_ovf   <= n_o_ovf;
        r_o_fin   <= n_o_fin;
    end

    assign o_out_valid      = r_ov;
    assign o_job_id         = r_o_id;
    assign o_job_burst      = r_o_burst;
    assign o_wait_time      = r_o_wait;
    assign o_turnaround     = r_o_turn;
    assign o_avg_wait       = r_o_avg_w;
    assign o_avg_turnaround = r_o_avg_t;
    assign o_overflowed     = r_o_ovf;
    assign o_final_result   = r_o_fin;

endmodule

>>> rtl/core/psw_checker.sv
// ----------------------------------------------------------------------------
// psw_checker
// Port-level checks of the priority scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [15:0] i_burst_time,
    input logic [7:0]  i_job_priority,
    input logic        i_last_job,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  o_job_id,
    input logic [15:0] o_job_burst,
    input logic [19:0] o_wait_time,
    input logic [19:0] o_turnaround,
    input logic [19:0] o_avg_wait,
    input logic [19:0] o_avg_turnaround,
    input logic        o_overflowed,
    input logic        o_final_result
);

    // a stalled result keeps its id, burst, wait time and final mark
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_job_id) && $stable(o_job_burst)
            && $stable(o_wait_time) && $stable(o_final_result))
        else $error("result changed while stalled");

    // averages and overflow only on the final result of a schedule
    a_nonfinal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_result |->
            o_avg_wait == 20'd0 && o_avg_turnaround == 20'd0 && !o_overflowed)
        else $error("summary fields set on a non-final result");

    // no new job is taken while a schedule is still being reported
    a_busy_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_final_result |-> !o_in_ready)
        else $error("input ready in the middle of a schedule");

    a_turn_ge_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_turnaround >= o_wait_time
            && o_avg_turnaround >= o_avg_wait)
        else $error("turnaround below wait time");

    // a job marked last drops the input ready right after it is taken
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_job |=> !o_in_ready)
        else $error("input ready right after the last job");

endmodule

bind priority_schedule_wait_times psw_checker u_psw_checker (.*);
